/* sv/mlpq_pkg.sv */
// ----------------------------------------------------------------------------
// mlpq_pkg: shared types and constants of the multi-level priority queue
// Sizes of the shared store, operation and status codes, controller types.
// ----------------------------------------------------------------------------
package mlpq_pkg;

	localparam int LEVELS     = 10;
	localparam int CAPACITY   = 256;
	localparam int DATA_WIDTH = 32;

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int LV_W   = $clog2(LEVELS);

	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [CNT_W-1:0]      count_t;
	typedef logic [LV_W-1:0]       level_t;
	typedef logic [DATA_WIDTH-1:0] entry_t;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPRI = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
	} cmd_t;

endpackage

/* sv/mlpq_req_if.sv */
// ----------------------------------------------------------------------------
// mlpq_req_if: request channel of the multi-level priority queue
// Valid/ready channel carrying one enqueue or dequeue request per beat.
// ----------------------------------------------------------------------------
interface mlpq_req_if ();
	logic        valid;
	logic        ready;
	logic        operation;
	logic [3:0]  priority_req;
	logic [31:0] entry_data;

	modport source (output valid, output operation, output priority_req,
		output entry_data, input ready);
	modport sink (input valid, input operation, input priority_req,
		input entry_data, output ready);
endinterface

/* sv/mlpq_rsp_if.sv */
// ----------------------------------------------------------------------------
// mlpq_rsp_if: response channel of the multi-level priority queue
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface mlpq_rsp_if ();
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] out_data;
	logic [3:0]  out_priority;
	logic [8:0]  total_count;

	modport source (output valid, output status, output out_data,
		output out_priority, output total_count, input ready);
	modport sink (input valid, input status, input out_data,
		input out_priority, input total_count, output ready);
endinterface

/* sv/mlpq_ram.sv */
// ----------------------------------------------------------------------------
// mlpq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mlpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/mlpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mlpq_ctrl: sequencing controller of the multi-level priority queue
// Accepts a request, runs the update cycle and holds the result beat.
// ----------------------------------------------------------------------------
module mlpq_ctrl import mlpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready   = arst_n && (!out_valid_q || out_ready);
				cmd.accept = in_valid && in_ready;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* sv/mlpq_dp.sv */
// ----------------------------------------------------------------------------
// mlpq_dp: datapath of the multi-level priority queue
// Level head/tail pointers, free stack, shared entry and link stores.
// ----------------------------------------------------------------------------
module mlpq_dp import mlpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        req_operation,
	input  logic [3:0]  req_priority,
	input  logic [31:0] req_data,
	output logic [1:0]  rsp_status,
	output logic [31:0] rsp_data,
	output logic [3:0]  rsp_priority,
	output logic [8:0]  rsp_count
);

	slot_t             head_q [LEVELS];
	slot_t             tail_q [LEVELS];
	logic [LEVELS-1:0] nonempty_q;
	slot_t             free_head_q;
	logic              free_valid_q;
	count_t            fresh_q;
	count_t            count_q;

	op_t    op_s1;
	level_t lv_s1;
	entry_t data_s1;
	logic   pri_ok_s1;
	logic   found_s1;

	logic        found;
	level_t      top_lv;
	level_t      acc_lv;
	logic        pri_ok;
	slot_t       rd_addr;
	logic [63:0] in_ext;

	entry_t      entry_rd;
	slot_t       link_rd;
	logic        link_we;
	slot_t       link_waddr;
	slot_t       link_wdata;

	logic        enq_ok;
	logic        deq_ok;
	slot_t       new_slot;
	slot_t       deq_slot;
	count_t      count_d;
	status_t     status_d;
	logic [63:0] out_ext;
	logic [15:0] cnt_ext;

	always_comb begin
		found  = 1'b0;
		top_lv = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				found  = 1'b1;
				top_lv = LV_W'(i);
			end
		end
	end

	assign pri_ok  = (req_priority != 4'd0) && ({1'b0, req_priority} <= 5'(LEVELS));
	assign acc_lv  = (op_t'(req_operation) == OP_DEQ) ? top_lv : LV_W'(req_priority - 4'd1);
	assign rd_addr = (op_t'(req_operation) == OP_DEQ) ? head_q[top_lv] : free_head_q;
	assign in_ext  = 64'(req_data);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_s1     <= op_t'(req_operation);
			lv_s1     <= acc_lv;
			data_s1   <= in_ext[DATA_WIDTH-1:0];
			pri_ok_s1 <= pri_ok;
			found_s1  <= found;
		end
	end

	assign enq_ok   = cmd.exec && (op_s1 == OP_ENQ) && pri_ok_s1 && (count_q < CNT_W'(CAPACITY));
	assign deq_ok   = cmd.exec && (op_s1 == OP_DEQ) && found_s1;
	assign new_slot = free_valid_q ? free_head_q : fresh_q[SLOT_W-1:0];
	assign deq_slot = head_q[lv_s1];

	assign link_we    = (enq_ok && nonempty_q[lv_s1]) || (deq_ok && free_valid_q);
	assign link_waddr = enq_ok ? tail_q[lv_s1] : deq_slot;
	assign link_wdata = enq_ok ? new_slot : free_head_q;

	mlpq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_entry_ram (
		.clk   (clk),
		.we    (enq_ok),
		.waddr (new_slot),
		.wdata (data_s1),
		.re    (cmd.accept),
		.raddr (rd_addr),
		.rdata (entry_rd)
	);

	mlpq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (cmd.accept),
		.raddr (rd_addr),
		.rdata (link_rd)
	);

	always_comb begin
		status_d = ST_OK;
		if (op_s1 == OP_ENQ) begin
			if (!pri_ok_s1) begin
				status_d = ST_BADPRI;
			end else if (count_q >= CNT_W'(CAPACITY)) begin
				status_d = ST_FULL;
			end
		end else if (!found_s1) begin
			status_d = ST_EMPTY;
		end
	end

	always_comb begin
		count_d = count_q;
		if (enq_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (deq_ok) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	assign out_ext = 64'(entry_rd);
	assign cnt_ext = 16'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q   <= '0;
			free_head_q  <= '0;
			free_valid_q <= 1'b0;
			fresh_q      <= '0;
			count_q      <= '0;
		end else begin
			count_q <= count_d;
			if (enq_ok) begin
				nonempty_q[lv_s1] <= 1'b1;
				if (free_valid_q) begin
					free_head_q  <= link_rd;
					free_valid_q <= (CNT_W+1)'(fresh_q) > ((CNT_W+1)'(count_q) + (CNT_W+1)'(1));
				end else begin
					fresh_q <= fresh_q + CNT_W'(1);
				end
			end else if (deq_ok) begin
				if (deq_slot == tail_q[lv_s1]) begin
					nonempty_q[lv_s1] <= 1'b0;
				end
				free_head_q  <= deq_slot;
				free_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq_ok) begin
			tail_q[lv_s1] <= new_slot;
			if (!nonempty_q[lv_s1]) begin
				head_q[lv_s1] <= new_slot;
			end
		end else if (deq_ok && (deq_slot != tail_q[lv_s1])) begin
			head_q[lv_s1] <= link_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_status   <= status_d;
			rsp_data     <= deq_ok ? out_ext[31:0] : 32'd0;
			rsp_priority <= deq_ok ? (4'(lv_s1) + 4'd1) : 4'd0;
			rsp_count    <= cnt_ext[8:0];
		end
	end

endmodule

/* sv/multi_level_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// multi_level_priority_queue_core: bucket priority queue over a shared store
// Enqueue to one of the levels, dequeue the oldest entry of the most urgent
// non-empty level; one result beat per request.
// ----------------------------------------------------------------------------
// Each request is handled in an accept step, which reads the entry and link
// stores at the free-stack top or at the chosen level's head, then an update
// step, which updates pointers, writes the stores and loads the result
// register. A new request is taken no earlier than the cycle in which the
// previous result beat is taken on rsp, so a request is never taken while
// the previous one is still being handled. The stores need no clearing after reset.
module multi_level_priority_queue_core import mlpq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	mlpq_req_if.sink   req,
	mlpq_rsp_if.source rsp
);

	cmd_t cmd;

	mlpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	mlpq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req_operation (req.operation),
		.req_priority  (req.priority_req),
		.req_data      (req.entry_data),
		.rsp_status    (rsp.status),
		.rsp_data      (rsp.out_data),
		.rsp_priority  (rsp.out_priority),
		.rsp_count     (rsp.total_count)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(rsp.valid && !rsp.ready))
		else $error("result beat overwritten before being taken");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (!req.ready && cmd.exec))
		else $error("request taken during update cycle");

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |->
		(rsp.out_data == 32'd0 && rsp.out_priority == 4'd0))
		else $error("failed request returned entry fields");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.out_priority != 4'd0) |->
		({1'b0, rsp.out_priority} <= 5'(LEVELS)))
		else $error("returned level out of range");

endmodule

/* dv/mlpq_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mlpq_result_checker: result prediction and comparison for the priority queue
// Watches both channels. Every request beat is run through a model built from
// one queue per level, and every result beat is compared field by field with
// the oldest prediction. Mismatches, results with no prediction and
// predictions left unanswered all count towards fail_count.
// ----------------------------------------------------------------------------
module mlpq_result_checker import mlpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic        req_operation,
	input  logic [3:0]  req_priority,
	input  logic [31:0] req_data,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic [1:0]  rsp_status,
	input  logic [31:0] rsp_data,
	input  logic [3:0]  rsp_priority,
	input  logic [8:0]  rsp_count,
	output int          fail_count
);

	typedef struct packed {
		status_t     status;
		logic [31:0] data;
		logic [3:0]  level;
		logic [8:0]  count;
	} queue_result_t;

	entry_t        level_fifo [LEVELS][$];
	int            held_entries = 0;
	queue_result_t expected_results [$];
	int            mismatches = 0;
	int            result_beats = 0;

	function automatic queue_result_t predict_queue_op(op_t op, logic [3:0] pri, entry_t data);
		queue_result_t res;
		res = '0;
		res.status = ST_OK;
		if (op == OP_ENQ) begin
			if (pri == 4'd0 || pri > LEVELS) begin
				res.status = ST_BADPRI;
			end else if (held_entries >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				level_fifo[pri - 1].push_back(data);
				held_entries++;
			end
		end else begin
			res.status = ST_EMPTY;
			for (int lv = 0; lv < LEVELS; lv++) begin
				if (res.status == ST_EMPTY && level_fifo[lv].size() != 0) begin
					res.data = 32'(level_fifo[lv].pop_front());
					res.level = 4'(lv + 1);
					res.status = ST_OK;
					held_entries--;
				end
			end
		end
		res.count = 9'(held_entries);
		return res;
	endfunction

	always @(posedge clk) begin : monitor
		queue_result_t want;
		queue_result_t got;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				got.status = status_t'(rsp_status);
				got.data   = rsp_data;
				got.level  = rsp_priority;
				got.count  = rsp_count;
				result_beats++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: beat %0d unexpected: %0d/%h/%0d/%0d",
							$realtime, result_beats, got.status, got.data,
							got.level, got.count);
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status || got.data !== want.data ||
							got.level !== want.level || got.count !== want.count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: beat %0d exp %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
								$realtime, result_beats, want.status, want.data,
								want.level, want.count, got.status, got.data,
								got.level, got.count);
					end
				end
			end
			if (req_valid && req_ready)
				expected_results.push_back(predict_queue_op(op_t'(req_operation),
					req_priority, req_data));
			fail_count = mismatches + expected_results.size();
		end
	end

endmodule

/* dv/multi_level_priority_queue_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_level_priority_queue_core_tb: testbench of the multi-level priority queue
// Directed beats for the empty, bad-priority and ordering cases, then random
// phases that mix traffic, fill the store past full and drain it past empty,
// with random idling on both channels. Checking is done by the result checker.
// ----------------------------------------------------------------------------
module multi_level_priority_queue_core_tb;
	import mlpq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n;
	logic calm = 1'b0;
	int   gap_pct = 25;
	int   stall_pct = 30;
	int   req_beats = 0;
	int   rsp_beats = 0;
	int   fail_count;

	mlpq_req_if req_ch ();
	mlpq_rsp_if rsp_ch ();

	multi_level_priority_queue_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	mlpq_result_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_ch.valid),
		.req_ready     (req_ch.ready),
		.req_operation (req_ch.operation),
		.req_priority  (req_ch.priority_req),
		.req_data      (req_ch.entry_data),
		.rsp_valid     (rsp_ch.valid),
		.rsp_ready     (rsp_ch.ready),
		.rsp_status    (rsp_ch.status),
		.rsp_data      (rsp_ch.out_data),
		.rsp_priority  (rsp_ch.out_priority),
		.rsp_count     (rsp_ch.total_count),
		.fail_count    (fail_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			req_beats <= req_beats + 1;
		if (rsp_ch.valid && rsp_ch.ready)
			rsp_beats <= rsp_beats + 1;
	end

	task automatic send_request(input op_t op, input logic [3:0] pri, input entry_t data);
		if (!calm && $urandom_range(99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(13, 1)) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.operation    <= op;
		req_ch.priority_req <= pri;
		req_ch.entry_data   <= data;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_random(input int deq_pct, input int wild_pct);
		op_t        op;
		logic [3:0] pri;
		op = ($urandom_range(99) < deq_pct) ? OP_DEQ : OP_ENQ;
		if (op == OP_DEQ || $urandom_range(99) < wild_pct)
			pri = 4'($urandom_range(15, 0));
		else
			pri = 4'($urandom_range(LEVELS, 1));
		send_request(op, pri, entry_t'($urandom));
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (rsp_beats != req_beats);
	endtask

	initial begin
		forever begin
			if (!calm && $urandom_range(99) < stall_pct) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(13, 1)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(20, 1)) @(posedge clk);
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("multi_level_priority_queue_core test failed");
		$finish;
	end

	initial begin
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.operation    <= OP_ENQ;
		req_ch.priority_req <= 4'd0;
		req_ch.entry_data   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_DEQ, 4'd15, 32'hffff_ffff);
		send_request(OP_ENQ, 4'd0, 32'hffff_ffff);
		send_request(OP_ENQ, 4'd11, 32'h0000_0000);
		send_request(OP_ENQ, 4'd15, 32'h1234_5678);
		send_request(OP_ENQ, 4'd10, 32'h0000_0000);
		send_request(OP_ENQ, 4'd1, 32'hffff_ffff);
		send_request(OP_ENQ, 4'd5, 32'ha5a5_a5a5);
		send_request(OP_ENQ, 4'd1, 32'h5a5a_5a5a);
		send_request(OP_ENQ, 4'd10, 32'h0000_0001);
		send_request(OP_ENQ, 4'd2, 32'h8000_0000);
		repeat (6) send_request(OP_DEQ, 4'd0, 32'h0000_0000);
		send_request(OP_DEQ, 4'd1, 32'hffff_ffff);
		send_request(OP_ENQ, 4'd3, 32'h7fff_ffff);
		send_request(OP_DEQ, 4'd0, 32'h0000_0000);
		wait_drained();

		// mixed traffic
		gap_pct = 30;
		stall_pct = 30;
		repeat (60) send_random(45, 25);
		wait_drained();

		// fill past full
		gap_pct = 10;
		stall_pct = 0;
		repeat (275) send_random(0, 3);

		// drain past empty
		gap_pct = 40;
		stall_pct = 20;
		repeat (300) send_random(96, 10);
		wait_drained();

		calm = 1'b1;
		repeat (30) send_random(50, 25);
		wait_drained();
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("multi_level_priority_queue_core test passed");
		else
			$display("multi_level_priority_queue_core test failed");
		$finish;
	end

endmodule
